/* hdl/tep_pkg.sv */
// Shared types and constants for the timed event playback block.
// No dependencies; used by timed_event_playback.
`default_nettype none

package tep_pkg;

	localparam int MAX_EVENTS_DEF = 256;
	localparam int HOLD_BITS_DEF  = 16;
	localparam int FUNC_W         = 2;
	localparam int HOLD_IN_W      = 16;
	localparam int STATE_W        = 16;

	// Function codes carried on the input word.
	typedef enum logic [FUNC_W-1:0] {
		FUNC_APPEND  = 2'd0,
		FUNC_RESTART = 2'd1,
		FUNC_TICK    = 2'd2,
		FUNC_NONE    = 2'd3
	} func_t;

	// Sequencer states, one-hot.
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_LOAD = 2'b10
	} seq_state_t;

endpackage : tep_pkg

`default_nettype wire

/* hdl/tep_event_mem.sv */
// Event store: one write port and one registered read port.
// Stands alone; instantiated by timed_event_playback.
`default_nettype none

module tep_event_mem #(
	parameter int DEPTH  = 256,
	parameter int WIDTH  = 32,
	parameter int ADDR_W = 8
) (
	input  wire logic              clk,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]  wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [WIDTH-1:0]  rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule : tep_event_mem

`default_nettype wire

/* hdl/timed_event_playback.sv */
// Timed event playback: records (hold, state) events and plays them back on ticks.
// Depends on tep_pkg and tep_event_mem.
// Results are registered; a tick that loads an event first reads the event store, and
// its registered read data reaches the output register from the load state.
// Throughput: one word per cycle while the output is taken; a loading tick stalls input.
// Reset clears the event count, play index, hold counter, held state and output register;
// the event store itself is not cleared, as entries are only read once written.
`default_nettype none

module timed_event_playback #(
	parameter int MAX_EVENTS = tep_pkg::MAX_EVENTS_DEF,
	parameter int HOLD_BITS  = tep_pkg::HOLD_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [tep_pkg::FUNC_W-1:0]    func,
	input  wire logic [tep_pkg::HOLD_IN_W-1:0] hold_ticks,
	input  wire logic [tep_pkg::STATE_W-1:0]   state_word,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic      [tep_pkg::STATE_W-1:0]   current_state,
	output logic                               rejected
);

	localparam int IDX_W = $clog2(MAX_EVENTS);
	localparam int CNT_W = $clog2(MAX_EVENTS + 1);
	localparam int MEM_W = HOLD_BITS + tep_pkg::STATE_W;
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_EVENTS);

	// Control state lives in flops; the events themselves live in the store.
	tep_pkg::seq_state_t            state_q;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               idx_q;
	logic [HOLD_BITS-1:0]           rem_q;
	logic [tep_pkg::STATE_W-1:0]    held_q;
	logic                           out_valid_q;
	logic [tep_pkg::STATE_W-1:0]    cur_state_q;
	logic                           rejected_q;

	logic                           accept;
	logic                           is_full;
	logic                           do_append;
	logic                           do_load;
	logic [CNT_W-1:0]               sel_idx;
	logic [HOLD_BITS-1:0]           hold_sat;
	logic [MEM_W-1:0]               rd_data;
	logic [HOLD_BITS-1:0]           rd_hold;
	logic [tep_pkg::STATE_W-1:0]    rd_state;

	// A word is only taken when the sequencer is idle and the output register
	// is empty or is being emptied at this very edge.
	assign in_ready = (state_q == tep_pkg::ST_IDLE) && (!out_valid_q || out_ready);
	assign accept   = in_valid && in_ready;

	assign is_full   = (count_q == CNT_MAX);
	assign do_append = accept && (tep_pkg::func_t'(func) == tep_pkg::FUNC_APPEND) && !is_full;

	// A tick loads the next event when the list is non-empty and the hold has run out.
	assign do_load = accept && (tep_pkg::func_t'(func) == tep_pkg::FUNC_TICK)
		&& (count_q != '0) && (rem_q == '0);

	// The play index wraps to the first event once it has run past the last.
	assign sel_idx = (idx_q >= count_q) ? '0 : idx_q;

	// Incoming hold values wider than the stored hold saturate.
	generate
		if (HOLD_BITS >= tep_pkg::HOLD_IN_W) begin : g_hold_wide
			assign hold_sat = HOLD_BITS'(hold_ticks);
		end else begin : g_hold_narrow
			assign hold_sat = (|hold_ticks[tep_pkg::HOLD_IN_W-1:HOLD_BITS])
				? '1 : hold_ticks[HOLD_BITS-1:0];
		end
	endgenerate

	assign rd_hold  = rd_data[MEM_W-1:tep_pkg::STATE_W];
	assign rd_state = rd_data[tep_pkg::STATE_W-1:0];

	tep_event_mem #(
		.DEPTH  (MAX_EVENTS),
		.WIDTH  (MEM_W),
		.ADDR_W (IDX_W)
	) u_mem (
		.clk     (clk),
		.wr_en   (do_append),
		.wr_addr (count_q[IDX_W-1:0]),
		.wr_data ({hold_sat, state_word}),
		.rd_en   (do_load),
		.rd_addr (sel_idx[IDX_W-1:0]),
		.rd_data (rd_data)
	);

	// Sequencer and playback state. Appends, restarts and non-loading ticks
	// complete in the accepting cycle; a loading tick waits in ST_LOAD for the
	// store to return the event, which then becomes the held state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tep_pkg::ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			rem_q   <= '0;
			held_q  <= '0;
		end else begin
			unique case (state_q)
				tep_pkg::ST_IDLE: begin
					if (accept) begin
						unique case (tep_pkg::func_t'(func))
							tep_pkg::FUNC_APPEND: begin
								if (!is_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							tep_pkg::FUNC_RESTART: begin
								idx_q  <= '0;
								rem_q  <= '0;
								held_q <= '0;
							end
							tep_pkg::FUNC_TICK: begin
								if (count_q != '0) begin
									if (rem_q != '0) begin
										rem_q <= rem_q - HOLD_BITS'(1);
									end else begin
										idx_q   <= sel_idx + CNT_W'(1);
										state_q <= tep_pkg::ST_LOAD;
									end
								end
							end
							default: begin
							end
						endcase
					end
				end
				tep_pkg::ST_LOAD: begin
					held_q  <= rd_state;
					rem_q   <= rd_hold;
					state_q <= tep_pkg::ST_IDLE;
				end
				default: begin
					state_q <= tep_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// Output register. The held state after a restart is zero, so that case
	// is presented directly rather than waiting for the held register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			cur_state_q <= '0;
			rejected_q  <= 1'b0;
		end else if (state_q == tep_pkg::ST_LOAD) begin
			out_valid_q <= 1'b1;
			cur_state_q <= rd_state;
			rejected_q  <= 1'b0;
		end else if (accept && !do_load) begin
			out_valid_q <= 1'b1;
			cur_state_q <= (tep_pkg::func_t'(func) == tep_pkg::FUNC_RESTART) ? '0 : held_q;
			rejected_q  <= (tep_pkg::func_t'(func) == tep_pkg::FUNC_APPEND) && is_full;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign current_state = cur_state_q;
	assign rejected      = rejected_q;

endmodule : timed_event_playback

`default_nettype wire
